@@ hdl/rfla_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rfla_pkg;

  // Layout limits.
  localparam int unsigned MAX_RECORD_BYTES = 65536;
  localparam int unsigned MAX_ALIGN_BYTES  = 64;

  // Width of the internal layout arithmetic (bit positions with headroom).
  localparam int unsigned CALC_W = 22;

  // Queue between front and back end.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CALC_W-1:0] MAX_BYTES_C = CALC_W'(MAX_RECORD_BYTES);
  localparam logic [CALC_W-1:0] MAX_BITS_C  = CALC_W'(MAX_RECORD_BYTES * 8);
  localparam logic [6:0]        MAX_ALIGN_C = 7'(MAX_ALIGN_BYTES);

  // Configuration register indexes.
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t REG_ABI_MODE   = 2'd0;
  localparam cfg_index_t REG_PACK_TIGHT = 2'd1;
  localparam cfg_index_t REG_PACK_LIMIT = 2'd2;

  // Operation classes decided by the front end.
  typedef enum logic [3:0] {
    OP_END_UNION,
    OP_END_DECL,
    OP_END_DEFAULT,
    OP_UNION,
    OP_DECL_ZERO,
    OP_DECL_BF,
    OP_DECL_FIELD,
    OP_DEF_ZERO,
    OP_DEF_TIGHT,
    OP_DEF_BF,
    OP_DEF_FIELD
  } op_t;

  // One classified descriptor as it sits in the queue.
  typedef struct packed {
    op_t         op;
    logic        is_bf;
    logic [1:0]  code;
    logic [6:0]  unit_bits;
    logic [6:0]  width;
    logic [6:0]  ualign;
    logic [6:0]  falign;
    logic [15:0] size;
  } entry_t;

  // Largest power of two not above v; zero counts as one.
  function automatic logic [6:0] floor_pow2(input logic [6:0] v);
    logic [6:0] p;
    p = 7'd1;
    for (int i = 0; i < 7; i++) begin
      if (v[i]) p = 7'(1 << i);
    end
    return p;
  endfunction

  // Alignment after rounding, the global cap and the pack limit.
  function automatic logic [6:0] cap_align(input logic [6:0] a, input logic [6:0] pack);
    logic [6:0] f;
    logic [6:0] p;
    f = floor_pow2(a);
    if (f > MAX_ALIGN_C) f = MAX_ALIGN_C;
    p = floor_pow2(pack);
    if (pack != 7'd0 && f > p) f = p;
    return f;
  endfunction

  // Round x up to a multiple of the power of two a.
  function automatic logic [CALC_W-1:0] align_up(input logic [CALC_W-1:0] x,
                                                 input logic [9:0] a);
    logic [CALC_W-1:0] m;
    m = CALC_W'(a - 10'd1);
    return (x + m) & ~m;
  endfunction

endpackage

`default_nettype wire

@@ hdl/rfla_item_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface rfla_item_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        record_is_union;
  logic        is_bit_field;
  logic [6:0]  width_bits;
  logic [1:0]  unit_code;
  logic [6:0]  natural_align;
  logic [15:0] size_bytes;
  logic        flexible_array;

  modport source (
    output valid, req_type, record_is_union, is_bit_field, width_bits, unit_code,
           natural_align, size_bytes, flexible_array,
    input  ready
  );

  modport sink (
    input  valid, req_type, record_is_union, is_bit_field, width_bits, unit_code,
           natural_align, size_bytes, flexible_array,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/rfla_result_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface rfla_result_if;
  logic        valid;
  logic        ready;
  logic        is_summary;
  logic [15:0] offset_bytes;
  logic [5:0]  bit_pos;
  logic [6:0]  storage_size;
  logic [19:0] total_bits;
  logic [6:0]  record_align;
  logic        size_overflow;

  modport source (
    output valid, is_summary, offset_bytes, bit_pos, storage_size, total_bits,
           record_align, size_overflow,
    input  ready
  );

  modport sink (
    input  valid, is_summary, offset_bytes, bit_pos, storage_size, total_bits,
           record_align, size_overflow,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/rfla_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rfla_front (
  input  logic                 clk,
  input  logic                 rst,
  rfla_item_if.sink            item,
  input  logic                 cfg_wr_en,
  input  rfla_pkg::cfg_index_t cfg_index,
  input  logic [6:0]           cfg_wr_data,
  output logic                 push_valid,
  input  logic                 push_ready,
  output rfla_pkg::entry_t     push_data
);
  import rfla_pkg::*;

  logic       abi_mode;
  logic       pack_tight;
  logic [6:0] pack_limit;

  logic [6:0]  unit_bits;
  logic [6:0]  width_c;
  logic [6:0]  ualign;
  logic [6:0]  nalign_c;
  logic [15:0] size_c;
  logic [6:0]  width_rnd;
  logic        tight;
  logic        zero_bf;
  op_t         op;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      abi_mode   <= 1'b0;
      pack_tight <= 1'b0;
      pack_limit <= 7'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ABI_MODE:   abi_mode   <= cfg_wr_data[0];
        REG_PACK_TIGHT: pack_tight <= cfg_wr_data[0];
        REG_PACK_LIMIT: pack_limit <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Operand cleanup: unit size, clamped width, capped alignments.
  always_comb begin
    unit_bits = 7'd8 << item.unit_code;
    width_c   = (item.width_bits > unit_bits) ? unit_bits : item.width_bits;
    ualign    = cap_align(7'd1 << item.unit_code, pack_limit);
    nalign_c  = cap_align(item.natural_align, pack_limit);
    size_c    = (item.size_bytes == 16'd0 && !item.flexible_array) ? 16'd1
                                                                   : item.size_bytes;
    width_rnd = (width_c + 7'd7) >> 3;
    tight     = pack_tight || (pack_limit == 7'd1);
    zero_bf   = item.is_bit_field && (width_c == 7'd0);
  end

  // Classification of the descriptor into one back-end operation.
  always_comb begin
    if (item.req_type) begin
      if (item.record_is_union) op = OP_END_UNION;
      else if (abi_mode)        op = OP_END_DECL;
      else                      op = OP_END_DEFAULT;
    end else if (item.record_is_union) begin
      op = OP_UNION;
    end else if (abi_mode) begin
      if (zero_bf)                op = OP_DECL_ZERO;
      else if (item.is_bit_field) op = OP_DECL_BF;
      else                        op = OP_DECL_FIELD;
    end else begin
      if (zero_bf)                         op = OP_DEF_ZERO;
      else if (item.is_bit_field && tight) op = OP_DEF_TIGHT;
      else if (item.is_bit_field)          op = OP_DEF_BF;
      else                                 op = OP_DEF_FIELD;
    end
  end

  // Queue entry; union members carry their size and alignment directly.
  always_comb begin
    push_data.op        = op;
    push_data.is_bf     = item.is_bit_field;
    push_data.code      = item.unit_code;
    push_data.unit_bits = unit_bits;
    push_data.width     = width_c;
    push_data.ualign    = ualign;
    push_data.falign    = item.is_bit_field ? ualign : nalign_c;
    push_data.size      = size_c;
    if (item.record_is_union && item.is_bit_field) begin
      push_data.size = abi_mode ? 16'(unit_bits >> 3) : 16'(width_rnd);
    end
  end

  assign push_valid = item.valid;
  assign item.ready = push_ready;

endmodule

`default_nettype wire

@@ hdl/rfla_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rfla_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  rfla_pkg::entry_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output rfla_pkg::entry_t pop_data
);
  import rfla_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

@@ hdl/rfla_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rfla_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  rfla_pkg::entry_t pop_data,
  rfla_result_if.source    result
);
  import rfla_pkg::*;

  // Layout state.
  logic [19:0] position;
  logic [16:0] unit_base_byte;
  logic [6:0]  open_unit_bits;
  logic [6:0]  bits_used_in_unit;
  logic [6:0]  largest_align;
  logic [16:0] union_largest_size;
  logic        overflow_seen;

  // Result register.
  logic        rsp_valid;
  logic        rsp_is_summary;
  logic [15:0] rsp_offset;
  logic [5:0]  rsp_bit;
  logic [6:0]  rsp_storage;
  logic [19:0] rsp_total;
  logic [6:0]  rsp_align;
  logic        rsp_overflow;

  entry_t            e;
  logic              take;
  logic [CALC_W-1:0] pos_w, usb_w, uls_w, la_w;
  logic [CALC_W-1:0] pos_bytes, open_end, cur_a1, c2, p, uend, unit_mask, ub_mask;
  logic [CALC_W-1:0] total, total8, off, bit_src;
  logic [CALC_W-1:0] position_next, unit_base_next, union_size_next;
  logic [9:0]        uab;
  logic [7:0]        tsum;
  logic [6:0]        open_next, used_next, largest_next, raise_a, stor_v;
  logic              fits, summary, raise_en, overflow_next;
  logic [15:0]       off_sat;
  logic [19:0]       total_sat;

  assign e         = pop_data;
  assign pop_ready = !rsp_valid || result.ready;
  assign take      = pop_valid && pop_ready;

  // Next layout state and result fields for the entry at the queue head.
  always_comb begin
    pos_w     = CALC_W'(position);
    usb_w     = CALC_W'(unit_base_byte);
    uls_w     = CALC_W'(union_largest_size);
    la_w      = CALC_W'(largest_align);
    pos_bytes = (pos_w + CALC_W'(7)) >> 3;
    open_end  = usb_w + CALC_W'(open_unit_bits >> 3);
    cur_a1    = (open_unit_bits != 7'd0) ? open_end : pos_bytes;
    uab       = {e.ualign, 3'b000};
    unit_mask = CALC_W'(e.unit_bits - 7'd1);
    ub_mask   = CALC_W'((e.unit_bits >> 3) - 7'd1);
    fits      = (open_unit_bits == e.unit_bits) &&
                ({1'b0, bits_used_in_unit} + {1'b0, e.width} <= {1'b0, e.unit_bits});
    uend      = (pos_w & ~CALC_W'(uab - 10'd1)) + CALC_W'(e.unit_bits);
    tsum      = {5'd0, pos_w[2:0]} + {1'b0, e.width} + 8'd7;

    c2              = '0;
    p               = pos_w;
    total           = '0;
    off             = '0;
    bit_src         = '0;
    stor_v          = 7'd0;
    summary         = 1'b0;
    raise_en        = 1'b0;
    raise_a         = e.ualign;
    position_next   = pos_w;
    unit_base_next  = usb_w;
    union_size_next = uls_w;
    open_next       = open_unit_bits;
    used_next       = bits_used_in_unit;

    case (e.op)
      OP_END_UNION: begin
        summary = 1'b1;
        total   = align_up(uls_w, la_w[9:0]);
      end
      OP_END_DECL: begin
        summary = 1'b1;
        total   = align_up(cur_a1, la_w[9:0]);
      end
      OP_END_DEFAULT: begin
        summary = 1'b1;
        total   = align_up(pos_bytes, la_w[9:0]);
      end
      OP_UNION: begin
        if (CALC_W'(e.size) > uls_w) union_size_next = CALC_W'(e.size);
        stor_v   = e.is_bf ? e.unit_bits : 7'd0;
        raise_en = 1'b1;
        raise_a  = e.falign;
      end
      OP_DECL_ZERO: begin
        // A zero-width bitfield closes the open unit and aligns to its own unit.
        if (open_unit_bits != 7'd0) begin
          open_next = 7'd0;
          used_next = 7'd0;
        end
        c2            = align_up(cur_a1, {3'b000, e.ualign});
        off           = c2;
        stor_v        = e.unit_bits;
        position_next = c2 << 3;
      end
      OP_DECL_BF: begin
        if (fits) begin
          off           = usb_w;
          bit_src       = CALC_W'(bits_used_in_unit);
          used_next     = bits_used_in_unit + e.width;
          position_next = pos_bytes << 3;
        end else begin
          // Start a fresh unit of the declared size.
          c2             = align_up(cur_a1, {3'b000, e.ualign});
          unit_base_next = c2;
          open_next      = e.unit_bits;
          used_next      = e.width;
          off            = c2;
          position_next  = c2 << 3;
        end
        stor_v   = e.unit_bits;
        raise_en = 1'b1;
      end
      OP_DECL_FIELD: begin
        if (open_unit_bits != 7'd0) begin
          open_next = 7'd0;
          used_next = 7'd0;
        end
        c2            = align_up(cur_a1, {3'b000, e.falign});
        off           = c2;
        position_next = (c2 + CALC_W'(e.size)) << 3;
        raise_en      = 1'b1;
        raise_a       = e.falign;
      end
      OP_DEF_ZERO: begin
        p             = align_up(pos_w, uab);
        position_next = p;
        off           = p >> 3;
        stor_v        = e.unit_bits;
        raise_en      = 1'b1;
      end
      OP_DEF_TIGHT: begin
        // Byte-stream packing: storage covers the touched bytes only.
        off           = pos_w >> 3;
        bit_src       = CALC_W'(pos_w[2:0]);
        stor_v        = {tsum[6:3], 3'b000};
        position_next = pos_w + CALC_W'(e.width);
        raise_en      = 1'b1;
      end
      OP_DEF_BF: begin
        // Move to the next unit boundary when the field would straddle it.
        p             = (pos_w + CALC_W'(e.width) > uend) ? uend : pos_w;
        off           = (p >> 3) & ~ub_mask;
        bit_src       = p & unit_mask;
        stor_v        = e.unit_bits;
        position_next = p + CALC_W'(e.width);
        raise_en      = 1'b1;
      end
      OP_DEF_FIELD: begin
        c2            = align_up(pos_bytes, {3'b000, e.falign});
        off           = c2;
        position_next = (c2 + CALC_W'(e.size)) << 3;
        raise_en      = 1'b1;
        raise_a       = e.falign;
      end
      default: ;
    endcase

    // Saturation and the sticky overflow flag.
    overflow_next = overflow_seen;
    if (summary) begin
      if (total > MAX_BYTES_C) overflow_next = 1'b1;
    end else begin
      if (position_next > MAX_BITS_C) begin
        position_next = MAX_BITS_C;
        overflow_next = 1'b1;
      end
      if (unit_base_next > MAX_BYTES_C) begin
        unit_base_next = MAX_BYTES_C;
        overflow_next  = 1'b1;
      end
      if (union_size_next > MAX_BYTES_C) begin
        union_size_next = MAX_BYTES_C;
        overflow_next   = 1'b1;
      end
    end

    largest_next = (raise_en && raise_a > largest_align) ? raise_a : largest_align;
    off_sat      = (off > CALC_W'(16'hFFFF)) ? 16'hFFFF : off[15:0];
    total8       = total << 3;
    total_sat    = (total8 > CALC_W'(20'hFFFFF)) ? 20'hFFFFF : total8[19:0];
  end

  // State update; an end beat clears the record.
  always_ff @(posedge clk) begin
    if (rst) begin
      position           <= '0;
      unit_base_byte     <= '0;
      open_unit_bits     <= '0;
      bits_used_in_unit  <= '0;
      largest_align      <= 7'd1;
      union_largest_size <= '0;
      overflow_seen      <= 1'b0;
    end else if (take) begin
      if (summary) begin
        position           <= '0;
        unit_base_byte     <= '0;
        open_unit_bits     <= '0;
        bits_used_in_unit  <= '0;
        largest_align      <= 7'd1;
        union_largest_size <= '0;
        overflow_seen      <= 1'b0;
      end else begin
        position           <= position_next[19:0];
        unit_base_byte     <= unit_base_next[16:0];
        open_unit_bits     <= open_next;
        bits_used_in_unit  <= used_next;
        largest_align      <= largest_next;
        union_largest_size <= union_size_next[16:0];
        overflow_seen      <= overflow_next;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (result.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      rsp_is_summary <= summary;
      rsp_offset     <= summary ? 16'd0 : off_sat;
      rsp_bit        <= summary ? 6'd0 : bit_src[5:0];
      rsp_storage    <= summary ? 7'd0 : stor_v;
      rsp_total      <= summary ? total_sat : 20'd0;
      rsp_align      <= summary ? largest_align : 7'd1;
      rsp_overflow   <= overflow_next;
    end
  end

  assign result.valid         = rsp_valid;
  assign result.is_summary    = rsp_is_summary;
  assign result.offset_bytes  = rsp_offset;
  assign result.bit_pos       = rsp_bit;
  assign result.storage_size  = rsp_storage;
  assign result.total_bits    = rsp_total;
  assign result.record_align  = rsp_align;
  assign result.size_overflow = rsp_overflow;

endmodule

`default_nettype wire

@@ hdl/record_field_layout_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A descriptor accepted on the item channel is written into the queue; the back end takes it
// from the queue head and registers its result, which the result channel then presents.
// Throughput: one descriptor per cycle while results are taken, set by the back-end layout update.
// The two-entry queue keeps input beats flowing while one result waits to be taken.
// Reset (rst, synchronous, active high) clears the layout state, zeroes the configuration
// registers, empties the queue and drops any pending result.

module record_field_layout_allocator (
  input  logic                 clk,
  input  logic                 rst,
  rfla_item_if.sink            item,
  rfla_result_if.source        result,
  input  logic                 cfg_wr_en,
  input  rfla_pkg::cfg_index_t cfg_index,
  input  logic [6:0]           cfg_wr_data
);
  import rfla_pkg::*;

  logic   push_valid;
  logic   push_ready;
  entry_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_data;

  // Accept, configure and classify.
  rfla_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  // Decoupling queue.
  rfla_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Layout state and result register.
  rfla_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule

`default_nettype wire
